// ===== hdl/jsu_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescaper.
// ---------------------------------------------------------------------------
package jsu_pkg;

    localparam int unsigned QueueDepth = 4;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [2:0] ERR_NO_QUOTE     = 3'd0;
    localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd1;
    localparam logic [2:0] ERR_BAD_HEX      = 3'd2;
    localparam logic [2:0] ERR_BAD_LOW_SURR = 3'd3;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd4;
    localparam logic [2:0] ERR_BAD_UTF8     = 3'd5;
    localparam logic [2:0] ERR_LONE_LOW     = 3'd6;

    // One input byte's results: last_idx + 1 results, byte k in bytes[8k+:8]
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  err;
        logic [1:0]  last_idx;
        logic [31:0] bytes;
    } t_burst;

endpackage
`default_nettype wire

// ===== hdl/jsu_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// jsu_front
// Parser: classifies each input byte and forms its burst of results.
// ---------------------------------------------------------------------------
module jsu_front
    import jsu_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_accept,
    input  wire logic [7:0] i_byte,
    input  wire logic   i_eoi,
    output t_burst      o_burst,
    output logic        o_push
);

    localparam logic [2:0] M_WAIT = 3'd0;
    localparam logic [2:0] M_STR  = 3'd1;
    localparam logic [2:0] M_ESC  = 3'd2;
    localparam logic [2:0] M_HEX1 = 3'd3;
    localparam logic [2:0] M_BSL  = 3'd4;
    localparam logic [2:0] M_U    = 3'd5;
    localparam logic [2:0] M_HEX2 = 3'd6;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_hex, n_hex;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_hs, n_hs;
    logic [1:0]  r_pend, n_pend;
    logic [2:0]  r_cls, n_cls;

    logic        push;
    t_burst      burst;
    logic        is_hex;
    logic [3:0]  hv;
    logic [15:0] hex_new;
    logic [20:0] cp;
    logic [10:0] cp_hi;
    logic [7:0]  lo, hi;

    always_comb begin
        is_hex = 1'b1;
        hv     = i_byte[3:0];
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hv = i_byte[3:0];
        end else if ((i_byte >= 8'h61 && i_byte <= 8'h66) ||
                     (i_byte >= 8'h41 && i_byte <= 8'h46)) begin
            hv = i_byte[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
    end

    assign hex_new = {r_hex[11:0], hv};
    assign cp_hi   = {1'b0, r_hs} + 11'h040;

    always_comb begin
        lo = 8'h80;
        hi = 8'hBF;
        unique case (r_cls)
            3'd1:    lo = 8'hA0;
            3'd2:    hi = 8'h9F;
            3'd3:    lo = 8'h90;
            3'd4:    hi = 8'h8F;
            default: ;
        endcase
    end

    always_comb begin
        n_mode = r_mode;
        n_hex  = r_hex;
        n_cnt  = r_cnt;
        n_hs   = r_hs;
        n_pend = r_pend;
        n_cls  = r_cls;
        push   = 1'b0;
        burst  = '0;
        burst.kind = KIND_BYTE;
        cp     = '0;

        unique case (r_mode) inside
            M_WAIT: begin
                if (i_byte == CH_QUOTE) begin
                    n_mode = M_STR;
                    n_hex  = '0;
                    n_cnt  = '0;
                    n_hs   = '0;
                    n_pend = '0;
                    n_cls  = '0;
                end else begin
                    push = 1'b1;
                    burst.kind = KIND_ERR;
                    burst.err  = ERR_NO_QUOTE;
                end
            end
            M_STR: begin
                if (r_pend != 2'd0) begin
                    if (i_byte < lo || i_byte > hi) begin
                        n_mode = M_WAIT;
                        push = 1'b1;
                        burst.kind = KIND_ERR;
                        burst.err  = ERR_BAD_UTF8;
                    end else begin
                        n_pend = r_pend - 2'd1;
                        n_cls  = '0;
                        push = 1'b1;
                        burst.bytes[7:0] = i_byte;
                    end
                end else if (i_byte == CH_QUOTE) begin
                    n_mode = M_WAIT;
                    push = 1'b1;
                    burst.kind = KIND_DONE;
                end else if (i_byte == CH_BSL) begin
                    n_mode = M_ESC;
                end else if (i_byte == 8'h00) begin
                    n_mode = M_WAIT;
                    push = 1'b1;
                    burst.kind = KIND_ERR;
                    burst.err  = ERR_UNTERMINATED;
                end else if (i_byte < 8'h80) begin
                    push = 1'b1;
                    burst.bytes[7:0] = i_byte;
                end else if (i_byte < 8'hC2 || i_byte > 8'hF4) begin
                    n_mode = M_WAIT;
                    push = 1'b1;
                    burst.kind = KIND_ERR;
                    burst.err  = ERR_BAD_UTF8;
                end else begin
                    n_cls = 3'd0;
                    if (i_byte < 8'hE0) begin
                        n_pend = 2'd1;
                    end else if (i_byte < 8'hF0) begin
                        n_pend = 2'd2;
                        if (i_byte == 8'hE0) n_cls = 3'd1;
                        else if (i_byte == 8'hED) n_cls = 3'd2;
                    end else begin
                        n_pend = 2'd3;
                        if (i_byte == 8'hF0) n_cls = 3'd3;
                        else if (i_byte == 8'hF4) n_cls = 3'd4;
                    end
                    push = 1'b1;
                    burst.bytes[7:0] = i_byte;
                end
            end
            M_ESC: begin
                n_mode = M_STR;
                push = 1'b1;
                case (i_byte) inside
                    8'h5C, 8'h2F, 8'h22: burst.bytes[7:0] = i_byte;
                    8'h6E: burst.bytes[7:0] = 8'h0A;
                    8'h72: burst.bytes[7:0] = 8'h0D;
                    8'h62: burst.bytes[7:0] = 8'h08;
                    8'h66: burst.bytes[7:0] = 8'h0C;
                    8'h74: burst.bytes[7:0] = 8'h09;
                    8'h75: begin
                        n_mode = M_HEX1;
                        n_hex  = '0;
                        n_cnt  = '0;
                        push   = 1'b0;
                    end
                    default: begin
                        n_mode = M_WAIT;
                        burst.kind = KIND_ERR;
                        burst.err  = ERR_BAD_ESCAPE;
                    end
                endcase
            end
            M_HEX1, M_HEX2: begin
                if (!is_hex) begin
                    n_mode = M_WAIT;
                    push = 1'b1;
                    burst.kind = KIND_ERR;
                    burst.err  = ERR_BAD_HEX;
                end else begin
                    n_hex = hex_new;
                    n_cnt = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        if (r_mode == M_HEX1) begin
                            if (hex_new[15:10] == 6'b110110) begin
                                n_hs   = hex_new[9:0];
                                n_mode = M_BSL;
                            end else if (hex_new[15:10] == 6'b110111) begin
                                n_mode = M_WAIT;
                                push = 1'b1;
                                burst.kind = KIND_ERR;
                                burst.err  = ERR_LONE_LOW;
                            end else begin
                                n_mode = M_STR;
                                push = 1'b1;
                                cp = {5'd0, hex_new};
                            end
                        end else begin
                            if (hex_new[15:10] != 6'b110111) begin
                                n_mode = M_WAIT;
                                push = 1'b1;
                                burst.kind = KIND_ERR;
                                burst.err  = ERR_BAD_LOW_SURR;
                            end else begin
                                n_mode = M_STR;
                                push = 1'b1;
                                cp = {cp_hi[10:0], hex_new[9:0]};
                            end
                        end
                        if (n_mode == M_STR) begin
                            if (cp < 21'h80) begin
                                burst.last_idx = 2'd0;
                                burst.bytes[7:0] = cp[7:0];
                            end else if (cp < 21'h800) begin
                                burst.last_idx = 2'd1;
                                burst.bytes[7:0]  = {3'b110, cp[10:6]};
                                burst.bytes[15:8] = {2'b10, cp[5:0]};
                            end else if (cp < 21'h10000) begin
                                burst.last_idx = 2'd2;
                                burst.bytes[7:0]   = {4'b1110, cp[15:12]};
                                burst.bytes[15:8]  = {2'b10, cp[11:6]};
                                burst.bytes[23:16] = {2'b10, cp[5:0]};
                            end else begin
                                burst.last_idx = 2'd3;
                                burst.bytes[7:0]   = {5'b11110, cp[20:18]};
                                burst.bytes[15:8]  = {2'b10, cp[17:12]};
                                burst.bytes[23:16] = {2'b10, cp[11:6]};
                                burst.bytes[31:24] = {2'b10, cp[5:0]};
                            end
                        end
                    end
                end
            end
            M_BSL: begin
                if (i_byte == CH_BSL) begin
                    n_mode = M_U;
                end else begin
                    n_mode = M_WAIT;
                    push = 1'b1;
                    burst.kind = KIND_ERR;
                    burst.err  = ERR_BAD_LOW_SURR;
                end
            end
            M_U: begin
                if (i_byte == 8'h75) begin
                    n_mode = M_HEX2;
                    n_hex  = '0;
                    n_cnt  = '0;
                end else begin
                    n_mode = M_WAIT;
                    push = 1'b1;
                    burst.kind = KIND_ERR;
                    burst.err  = ERR_BAD_LOW_SURR;
                end
            end
            default: n_mode = M_WAIT;
        endcase

        // end of input with the string still open overrides everything
        if (i_eoi && n_mode != M_WAIT) begin
            n_mode = M_WAIT;
            push   = 1'b1;
            burst  = '0;
            burst.kind = KIND_ERR;
            burst.err  = ERR_UNTERMINATED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_WAIT;
            r_hex  <= '0;
            r_cnt  <= '0;
            r_hs   <= '0;
            r_pend <= '0;
            r_cls  <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_cnt  <= n_cnt;
            r_hs   <= n_hs;
            r_pend <= n_pend;
            r_cls  <= n_cls;
        end
    end

    assign o_burst = burst;
    assign o_push  = i_accept & push;

endmodule
`default_nettype wire

// ===== hdl/jsu_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// jsu_queue
// Short FIFO of result bursts between parser and output sequencer.
// ---------------------------------------------------------------------------
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_burst    i_burst,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_burst    o_head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [AW-1:0] PTR_ONE  = AW'(1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    t_burst        r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_pop;

    assign do_pop = i_pop & (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_ONE;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_ONE;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_ONE;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - CNT_ONE;
            end
        end
    end

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

endmodule
`default_nettype wire

// ===== hdl/jsu_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// jsu_back
// Output sequencer: unrolls each burst into single result transactions.
// ---------------------------------------------------------------------------
module jsu_back
    import jsu_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_valid,
    input  t_burst      i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_byte,
    output logic [2:0]  o_err,
    output logic        o_last
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [1:0] r_kind;
    logic [7:0] r_byte;
    logic [2:0] r_err;
    logic       r_last;
    logic       load;
    logic       at_last;

    assign load    = i_q_valid & (~r_valid | i_ready);
    assign at_last = (r_idx == i_head.last_idx);
    assign o_pop   = load & at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= i_head.kind;
            r_byte <= i_head.bytes[{r_idx, 3'b000} +: 8];
            r_err  <= i_head.err;
            r_last <= at_last;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_byte  = r_byte;
    assign o_err   = r_err;
    assign o_last  = r_last;

endmodule
`default_nettype wire

// ===== hdl/json_string_unescape.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// json_string_unescape
// Streaming unescaper for quoted JSON strings, UTF-8 output.
// ---------------------------------------------------------------------------
// Input stream (s_*): one text byte per transaction, tlast marks the last
// byte available. Output stream (m_*): one result per transaction; tuser
// gives the kind (byte, done, error), tdata the byte and error code, tlast
// flags the final result caused by one input byte.
// The parser takes one byte per cycle unless the queue is full, and writes
// the byte's results, as one burst of up to four, into a four-entry queue;
// the output sequencer sends one result per cycle, while m_tready is high,
// from the queue head through an output register. The first result of a
// byte passes through the queue entry and then the output register.
// Throughput: one input byte per cycle while the output keeps up; a
// \u escape producing up to four UTF-8 bytes sends each as its own result,
// which the queue absorbs, so the output port sets the sustained rate.
// When the receiver stalls the queue fills and s_tready falls; nothing is
// dropped. Reset empties the queue and output register and returns the
// parser to waiting for an opening quote.
// ---------------------------------------------------------------------------
module json_string_unescape
    import jsu_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,   // end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [10:8] error_code
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast    // last_of_run
);

    logic   accept;
    logic   push;
    logic   full;
    logic   pop;
    logic   q_valid;
    t_burst burst;
    t_burst head;
    logic [7:0] out_byte;
    logic [2:0] out_err;

    assign s_tready = ~full;
    assign accept   = s_tvalid & ~full;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_tdata),
        .i_eoi    (s_tlast),
        .o_burst  (burst),
        .o_push   (push)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_burst (burst),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head)
    );

    jsu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head),
        .o_pop     (pop),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_kind    (m_tuser),
        .o_byte    (out_byte),
        .o_err     (out_err),
        .o_last    (m_tlast)
    );

    assign m_tdata = {5'd0, out_err, out_byte};

endmodule
`default_nettype wire
